// ----- hw/rtl/ilc_pkg.sv -----
// Shared types and constants for the image load controller.
// Holds the command and lifecycle codes and the byte-wide CRC-32 step.
// No dependencies.
package ilc_pkg;

  typedef enum logic [2:0] {
    ACT_BEGIN   = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_COMMIT  = 3'd2,
    ACT_RUN     = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_RESTART = 3'd5,
    ACT_DISCARD = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_EMPTY     = 3'd0,
    ST_RECEIVING = 3'd1,
    ST_STAGED    = 3'd2,
    ST_RUNNING   = 3'd3,
    ST_STOPPED   = 3'd4,
    ST_FAULTED   = 3'd5
  } life_state_t;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;

  // Widest begin-range sum: 20-bit address plus 21-bit size.
  localparam int BEGIN_SUM_W = 22;

  // Reflected CRC-32 over one byte, with inversion on entry and exit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = ~crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return ~c;
  endfunction

endpackage

// ----- hw/rtl/image_load_controller_unit.sv -----
// Image load controller top level: input register, command logic, result register.
// Depends on ilc_pkg for command codes, lifecycle codes and the CRC-32 step.
//
// Takes one command word per cycle while the output is not stalled and returns
// exactly one result word for each. A command is captured in an input register,
// decoded against the lifecycle state in the following cycle and its result is
// registered in the result register that drives the outputs. The state update
// (byte count, running CRC-32, lifecycle, workload id) is computed combinationally
// by the command logic, which lets back-to-back commands, including image bytes,
// stream at one per cycle while the output is not stalled. Writing cfg_wr_data
// is meant for when no command is in flight.
module image_load_controller_unit #(
  parameter int ADDR_SPACE_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_xfer_tag,
  input  logic        in_manifest_ok,
  input  logic [20:0] in_img_len,
  input  logic [19:0] in_dest_addr,
  input  logic [31:0] in_crc_value,
  input  logic [19:0] in_offset,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_job_req,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [2:0]  out_state,
  output logic        out_mem_write,
  output logic [19:0] out_mem_address,
  output logic [7:0]  out_mem_data,
  output logic        out_publish,
  output logic [31:0] out_current_workload
);

  localparam int SPACE_W = $clog2(ADDR_SPACE_BYTES) + 1;
  localparam int CMP_W   = (SPACE_W > ilc_pkg::BEGIN_SUM_W) ? SPACE_W : ilc_pkg::BEGIN_SUM_W;
  localparam logic [CMP_W-1:0] SPACE = CMP_W'(ADDR_SPACE_BYTES);

  // Configuration
  logic backing_r;

  // Input register
  logic        s1_valid_r;
  logic [2:0]  s1_action_r;
  logic [31:0] s1_xfer_tag_r;
  logic        s1_manifest_ok_r;
  logic [20:0] s1_img_len_r;
  logic [19:0] s1_dest_addr_r;
  logic [31:0] s1_crc_value_r;
  logic [19:0] s1_offset_r;
  logic [7:0]  s1_data_byte_r;
  logic [31:0] s1_job_req_r;

  // Lifecycle state
  ilc_pkg::life_state_t life_state_r, life_state_nxt;
  logic [31:0] active_transfer_r, active_transfer_nxt;
  logic [31:0] workload_r, workload_nxt;
  logic [20:0] bytes_rcvd_r, bytes_rcvd_nxt;
  logic [31:0] running_crc_r, running_crc_nxt;
  logic [20:0] size_exp_r, size_exp_nxt;
  logic [19:0] base_addr_r, base_addr_nxt;
  logic [31:0] manifest_crc_r, manifest_crc_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_accepted_r, out_accepted_nxt;
  ilc_pkg::life_state_t out_state_r;
  logic        out_mem_write_r, out_mem_write_nxt;
  logic [19:0] out_mem_address_r, out_mem_address_nxt;
  logic [7:0]  out_mem_data_r, out_mem_data_nxt;
  logic        out_publish_r, out_publish_nxt;
  logic [31:0] out_workload_r;

  logic out_ready;
  logic in_take;
  logic s1_fire;

  logic [CMP_W-1:0] begin_addr;
  logic [CMP_W-1:0] begin_end;
  logic             begin_ok;
  logic             id_match;
  logic [31:0]      workload_inc;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  assign begin_addr = CMP_W'(s1_dest_addr_r);
  assign begin_end  = CMP_W'(s1_dest_addr_r) + CMP_W'(s1_img_len_r);
  assign begin_ok   = backing_r && s1_manifest_ok_r && (s1_img_len_r != 21'd0) &&
                      (begin_addr < SPACE) && (begin_end <= SPACE) &&
                      (life_state_r != ilc_pkg::ST_RUNNING);
  assign id_match   = (workload_r != 32'd0) &&
                      ((s1_job_req_r == 32'd0) || (s1_job_req_r == workload_r));
  // Skip zero on wrap
  assign workload_inc = (workload_r == 32'hffff_ffff) ? 32'd1 : workload_r + 32'd1;

  always_comb begin
    life_state_nxt      = life_state_r;
    active_transfer_nxt = active_transfer_r;
    workload_nxt        = workload_r;
    bytes_rcvd_nxt      = bytes_rcvd_r;
    running_crc_nxt     = running_crc_r;
    size_exp_nxt        = size_exp_r;
    base_addr_nxt       = base_addr_r;
    manifest_crc_nxt    = manifest_crc_r;
    out_accepted_nxt    = 1'b0;
    out_mem_write_nxt   = 1'b0;
    out_mem_address_nxt = 20'd0;
    out_mem_data_nxt    = 8'd0;
    out_publish_nxt     = 1'b0;
    case (ilc_pkg::action_t'(s1_action_r))
      ilc_pkg::ACT_BEGIN: begin
        if (begin_ok) begin
          active_transfer_nxt = s1_xfer_tag_r;
          size_exp_nxt        = s1_img_len_r;
          base_addr_nxt       = s1_dest_addr_r;
          manifest_crc_nxt    = s1_crc_value_r;
          bytes_rcvd_nxt      = 21'd0;
          running_crc_nxt     = 32'd0;
          life_state_nxt      = ilc_pkg::ST_RECEIVING;
          out_accepted_nxt    = 1'b1;
        end
      end
      ilc_pkg::ACT_WRITE: begin
        if (life_state_r == ilc_pkg::ST_RECEIVING &&
            s1_xfer_tag_r == active_transfer_r &&
            {1'b0, s1_offset_r} == bytes_rcvd_r &&
            bytes_rcvd_r < size_exp_r) begin
          out_mem_write_nxt   = 1'b1;
          out_mem_address_nxt = base_addr_r + s1_offset_r;
          out_mem_data_nxt    = s1_data_byte_r;
          running_crc_nxt     = ilc_pkg::crc_byte(running_crc_r, s1_data_byte_r);
          bytes_rcvd_nxt      = bytes_rcvd_r + 21'd1;
          out_accepted_nxt    = 1'b1;
        end
      end
      ilc_pkg::ACT_COMMIT: begin
        if (life_state_r == ilc_pkg::ST_RECEIVING) begin
          if (s1_xfer_tag_r != active_transfer_r || bytes_rcvd_r != size_exp_r ||
              s1_crc_value_r != manifest_crc_r || running_crc_r != s1_crc_value_r) begin
            life_state_nxt = ilc_pkg::ST_FAULTED;
          end else begin
            out_publish_nxt  = 1'b1;
            workload_nxt     = workload_inc;
            life_state_nxt   = ilc_pkg::ST_STAGED;
            out_accepted_nxt = 1'b1;
          end
        end
      end
      ilc_pkg::ACT_RUN: begin
        if (id_match && (life_state_r == ilc_pkg::ST_STAGED ||
                         life_state_r == ilc_pkg::ST_STOPPED)) begin
          life_state_nxt   = ilc_pkg::ST_RUNNING;
          out_accepted_nxt = 1'b1;
        end
      end
      ilc_pkg::ACT_STOP: begin
        if (id_match && life_state_r == ilc_pkg::ST_RUNNING) begin
          life_state_nxt   = ilc_pkg::ST_STOPPED;
          out_accepted_nxt = 1'b1;
        end
      end
      ilc_pkg::ACT_RESTART: begin
        if (id_match && (life_state_r == ilc_pkg::ST_STAGED ||
                         life_state_r == ilc_pkg::ST_RUNNING ||
                         life_state_r == ilc_pkg::ST_STOPPED)) begin
          life_state_nxt   = ilc_pkg::ST_RUNNING;
          out_accepted_nxt = 1'b1;
        end
      end
      ilc_pkg::ACT_DISCARD: begin
        life_state_nxt      = ilc_pkg::ST_EMPTY;
        active_transfer_nxt = 32'd0;
        workload_nxt        = 32'd0;
        bytes_rcvd_nxt      = 21'd0;
        running_crc_nxt     = 32'd0;
        size_exp_nxt        = 21'd0;
        base_addr_nxt       = 20'd0;
        manifest_crc_nxt    = 32'd0;
        out_accepted_nxt    = 1'b1;
      end
      default: begin
        // unused code: drop, no state change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backing_r <= 1'b1;
    end else if (cfg_wr_en) begin
      backing_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r      <= in_action;
      s1_xfer_tag_r    <= in_xfer_tag;
      s1_manifest_ok_r <= in_manifest_ok;
      s1_img_len_r     <= in_img_len;
      s1_dest_addr_r   <= in_dest_addr;
      s1_crc_value_r   <= in_crc_value;
      s1_offset_r      <= in_offset;
      s1_data_byte_r   <= in_data_byte;
      s1_job_req_r     <= in_job_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_state_r      <= ilc_pkg::ST_EMPTY;
      active_transfer_r <= 32'd0;
      workload_r        <= 32'd0;
      bytes_rcvd_r      <= 21'd0;
      running_crc_r     <= 32'd0;
      size_exp_r        <= 21'd0;
      base_addr_r       <= 20'd0;
      manifest_crc_r    <= 32'd0;
    end else if (s1_fire) begin
      life_state_r      <= life_state_nxt;
      active_transfer_r <= active_transfer_nxt;
      workload_r        <= workload_nxt;
      bytes_rcvd_r      <= bytes_rcvd_nxt;
      running_crc_r     <= running_crc_nxt;
      size_exp_r        <= size_exp_nxt;
      base_addr_r       <= base_addr_nxt;
      manifest_crc_r    <= manifest_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_accepted_r    <= out_accepted_nxt;
      out_state_r       <= life_state_nxt;
      out_mem_write_r   <= out_mem_write_nxt;
      out_mem_address_r <= out_mem_address_nxt;
      out_mem_data_r    <= out_mem_data_nxt;
      out_publish_r     <= out_publish_nxt;
      out_workload_r    <= workload_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_accepted_r;
  assign out_state            = out_state_r;
  assign out_mem_write        = out_mem_write_r;
  assign out_mem_address      = out_mem_address_r;
  assign out_mem_data         = out_mem_data_r;
  assign out_publish          = out_publish_r;
  assign out_current_workload = out_workload_r;

  a_mem_write_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mem_write_r) |-> out_accepted_r)
    else $error("memory write reported on a refused command");

  a_publish_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_publish_r) |->
      (out_state_r == ilc_pkg::ST_STAGED && out_workload_r != 32'd0))
    else $error("publish without a staged image and a live workload id");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (life_state_r == ilc_pkg::ST_RECEIVING) |-> (bytes_rcvd_r <= size_exp_r))
    else $error("byte count ran past the image size");

  a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_ready) |=> ($stable(life_state_r) && $stable(bytes_rcvd_r) && s1_valid_r))
    else $error("state advanced while the result register was blocked");

endmodule

// ----- verif/image_load_controller_unit_tb.sv -----
// Self-checking testbench for image_load_controller_unit: directed table, then
// random load sessions and noise, with a predictor that models each command in order.
// Depends on ilc_pkg for the action and lifecycle codes and the CRC polynomial.
module image_load_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_SPACE = 1048576;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  // CRC-32 of a single zero byte
  localparam logic [31:0] CRC_OF_ZERO_BYTE = 32'hd202ef8d;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] xfer_tag;
    logic        manifest_ok;
    logic [20:0] img_len;
    logic [19:0] dest_addr;
    logic [31:0] crc_value;
    logic [19:0] offset;
    logic [7:0]  data_byte;
    logic [31:0] job_req;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  state;
    logic        mem_write;
    logic [19:0] mem_address;
    logic [7:0]  mem_data;
    logic        publish;
    logic [31:0] workload;
  } result_t;

  typedef struct {
    cmd_t    cmd;
    bit      fixed;
    result_t res;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [31:0] in_xfer_tag;
  logic        in_manifest_ok;
  logic [20:0] in_img_len;
  logic [19:0] in_dest_addr;
  logic [31:0] in_crc_value;
  logic [19:0] in_offset;
  logic [7:0]  in_data_byte;
  logic [31:0] in_job_req;
  logic        out_valid;
  logic        out_stall;
  logic        out_accepted;
  logic [2:0]  out_state;
  logic        out_mem_write;
  logic [19:0] out_mem_address;
  logic [7:0]  out_mem_data;
  logic        out_publish;
  logic [31:0] out_current_workload;

  // typed expectation travelling with the word on the bus
  logic    drv_has_fixed;
  result_t drv_fixed;

  // predictor state
  bit                   pr_backing;
  ilc_pkg::life_state_t pr_state;
  logic [31:0]          pr_transfer;
  logic [31:0]          pr_workload;
  logic [20:0]          pr_count;
  logic [31:0]          pr_crc;
  logic [20:0]          pr_size;
  logic [19:0]          pr_base;
  logic [31:0]          pr_manifest_crc;

  result_t       pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatches;
  int            words_sent;
  int            burst_left = 6;
  bit            no_gaps;
  int            hold_cycles;

  image_load_controller_unit #(.ADDR_SPACE_BYTES(ADDR_SPACE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_xfer_tag(in_xfer_tag),
    .in_manifest_ok(in_manifest_ok),
    .in_img_len(in_img_len),
    .in_dest_addr(in_dest_addr),
    .in_crc_value(in_crc_value),
    .in_offset(in_offset),
    .in_data_byte(in_data_byte),
    .in_job_req(in_job_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_state(out_state),
    .out_mem_write(out_mem_write),
    .out_mem_address(out_mem_address),
    .out_mem_data(out_mem_data),
    .out_publish(out_publish),
    .out_current_workload(out_current_workload)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reflected CRC-32, one byte, register kept inverted while shifting.
  function automatic logic [31:0] crc32_update_byte(input logic [31:0] crc,
                                                    input logic [7:0] b);
    logic [31:0] r;
    logic [7:0]  d;
    r = ~crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ d[0]) r = (r >> 1) ^ ilc_pkg::CRC_POLY;
      else r = r >> 1;
      d = d >> 1;
    end
    return ~r;
  endfunction

  function automatic void clear_model();
    pr_state = ilc_pkg::ST_EMPTY;
    pr_transfer = '0;
    pr_workload = '0;
    pr_count = '0;
    pr_crc = '0;
    pr_size = '0;
    pr_base = '0;
    pr_manifest_crc = '0;
  endfunction

  function automatic bit workload_matches(input logic [31:0] req);
    return pr_workload != 0 && (req == 0 || req == pr_workload);
  endfunction

  function automatic result_t predict_command(input cmd_t c);
    result_t    r;
    logic [21:0] span;
    r = '0;
    span = {2'b00, c.dest_addr} + {1'b0, c.img_len};
    case (c.action)
      ilc_pkg::ACT_BEGIN: begin
        if (pr_backing && c.manifest_ok && c.img_len != 0 &&
            c.dest_addr < ADDR_SPACE && span <= ADDR_SPACE &&
            pr_state != ilc_pkg::ST_RUNNING) begin
          pr_transfer = c.xfer_tag;
          pr_size = c.img_len;
          pr_base = c.dest_addr;
          pr_manifest_crc = c.crc_value;
          pr_count = '0;
          pr_crc = '0;
          pr_state = ilc_pkg::ST_RECEIVING;
          r.accepted = 1'b1;
        end
      end
      ilc_pkg::ACT_WRITE: begin
        if (pr_state == ilc_pkg::ST_RECEIVING && c.xfer_tag == pr_transfer &&
            {1'b0, c.offset} == pr_count && pr_count < pr_size) begin
          r.mem_write = 1'b1;
          r.mem_address = pr_base + c.offset;
          r.mem_data = c.data_byte;
          pr_crc = crc32_update_byte(pr_crc, c.data_byte);
          pr_count = pr_count + 21'd1;
          r.accepted = 1'b1;
        end
      end
      ilc_pkg::ACT_COMMIT: begin
        if (pr_state == ilc_pkg::ST_RECEIVING) begin
          if (c.xfer_tag != pr_transfer || pr_count != pr_size ||
              c.crc_value != pr_manifest_crc || pr_crc != c.crc_value) begin
            pr_state = ilc_pkg::ST_FAULTED;
          end else begin
            r.publish = 1'b1;
            pr_workload = pr_workload + 32'd1;
            if (pr_workload == 0) pr_workload = 32'd1;
            pr_state = ilc_pkg::ST_STAGED;
            r.accepted = 1'b1;
          end
        end
      end
      ilc_pkg::ACT_RUN: begin
        if (workload_matches(c.job_req) &&
            (pr_state == ilc_pkg::ST_STAGED || pr_state == ilc_pkg::ST_STOPPED)) begin
          pr_state = ilc_pkg::ST_RUNNING;
          r.accepted = 1'b1;
        end
      end
      ilc_pkg::ACT_STOP: begin
        if (workload_matches(c.job_req) && pr_state == ilc_pkg::ST_RUNNING) begin
          pr_state = ilc_pkg::ST_STOPPED;
          r.accepted = 1'b1;
        end
      end
      ilc_pkg::ACT_RESTART: begin
        if (workload_matches(c.job_req) && (pr_state == ilc_pkg::ST_STAGED ||
            pr_state == ilc_pkg::ST_RUNNING || pr_state == ilc_pkg::ST_STOPPED)) begin
          pr_state = ilc_pkg::ST_RUNNING;
          r.accepted = 1'b1;
        end
      end
      ilc_pkg::ACT_DISCARD: begin
        clear_model();
        r.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    r.state = pr_state;
    r.workload = pr_workload;
    return r;
  endfunction

  // Check both channels at every edge, against pre-edge values.
  always @(posedge clk) begin
    cmd_t    seen;
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen = {in_action, in_xfer_tag, in_manifest_ok, in_img_len,
                in_dest_addr, in_crc_value, in_offset, in_data_byte,
                in_job_req};
        want = predict_command(seen);
        pending_results.push_back(drv_has_fixed ? drv_fixed : want);
      end
      if (out_valid && !out_stall) begin
        got = {out_accepted, out_state, out_mem_write, out_mem_address,
               out_mem_data, out_publish, out_current_workload};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: acc=%0d st=%0d",
                                         got.accepted, got.state);
        end else begin
          want = pending_results.pop_front();
          if (got.accepted !== want.accepted || got.state !== want.state ||
              got.mem_write !== want.mem_write ||
              got.mem_address !== want.mem_address ||
              got.mem_data !== want.mem_data || got.publish !== want.publish ||
              got.workload !== want.workload) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected acc=%0d st=%0d mw=%0d ma=%05h md=%02h pub=%0d wl=%08h",
                       want.accepted, want.state, want.mem_write, want.mem_address,
                       want.mem_data, want.publish, want.workload);
              $display("          actual   acc=%0d st=%0d mw=%0d ma=%05h md=%02h pub=%0d wl=%08h",
                       got.accepted, got.state, got.mem_write, got.mem_address,
                       got.mem_data, got.publish, got.workload);
            end
          end
        end
      end
    end
  end

  // Receiver: changing stall patterns, or a long hold when one is requested.
  initial begin : result_stall
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic cmd_t mk_cmd(input logic [2:0] action, input logic [31:0] tid,
                                   input logic mok, input logic [20:0] size,
                                   input logic [19:0] addr, input logic [31:0] crc,
                                   input logic [19:0] offs, input logic [7:0] data,
                                   input logic [31:0] wid);
    return {action, tid, mok, size, addr, crc, offs, data, wid};
  endfunction

  function automatic result_t mk_res(input logic acc, input ilc_pkg::life_state_t st,
                                     input logic mw, input logic [19:0] ma,
                                     input logic [7:0] md, input logic pub,
                                     input logic [31:0] wl);
    return {acc, st, mw, ma, md, pub, wl};
  endfunction

  function automatic void add_checked(input cmd_t c, input result_t r);
    directed_row_t row;
    row.cmd = c;
    row.fixed = 1'b1;
    row.res = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_predicted(input cmd_t c);
    directed_row_t row;
    row.cmd = c;
    row.fixed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.action = 3'($urandom_range(0, 7));
    c.xfer_tag = $urandom;
    c.manifest_ok = 1'($urandom_range(0, 1));
    c.img_len = 21'($urandom);
    c.dest_addr = 20'($urandom);
    c.crc_value = $urandom;
    c.offset = 20'($urandom);
    c.data_byte = 8'($urandom);
    c.job_req = $urandom;
    return c;
  endfunction

  // Offer one word and hold it until taken; then maybe open a gap.
  task automatic send_word(input cmd_t c, input bit fixed, input result_t r);
    int gap;
    in_valid <= 1'b1;
    in_action <= c.action;
    in_xfer_tag <= c.xfer_tag;
    in_manifest_ok <= c.manifest_ok;
    in_img_len <= c.img_len;
    in_dest_addr <= c.dest_addr;
    in_crc_value <= c.crc_value;
    in_offset <= c.offset;
    in_data_byte <= c.data_byte;
    in_job_req <= c.job_req;
    drv_has_fixed <= fixed;
    drv_fixed <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c.action != ACT_UNUSED) words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send(input cmd_t c);
    send_word(c, 1'b0, '0);
  endtask

  // Let the last accepted word reach the queue before watching it empty.
  task automatic drain_results();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_backing(input bit v);
    in_valid <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pr_backing = v;
  endtask

  // One load: begin, bytes in order with the odd broken write, commit,
  // then some lifecycle commands and maybe a discard.
  task automatic image_session();
    cmd_t        c;
    logic [7:0]  img[$];
    logic [31:0] tid;
    logic [31:0] crc;
    int          len;
    int          n;
    int          i;
    int          pick;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
    tid = $urandom;
    crc = '0;
    for (i = 0; i < len; i++) begin
      img.push_back(8'($urandom));
      crc = crc32_update_byte(crc, img[i]);
    end
    c = random_cmd();
    c.action = ilc_pkg::ACT_BEGIN;
    c.xfer_tag = tid;
    c.manifest_ok = ($urandom_range(0, 15) != 0);
    c.img_len = 21'(len);
    c.dest_addr = ($urandom_range(0, 3) == 0) ? 20'(ADDR_SPACE - len)
                                              : 20'($urandom_range(0, ADDR_SPACE - len));
    c.crc_value = ($urandom_range(0, 9) == 0) ? ~crc : crc;
    send(c);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        c = random_cmd();
        c.action = ilc_pkg::ACT_WRITE;
        c.xfer_tag = ($urandom_range(0, 1) == 0) ? ~tid : tid;
        c.offset = (c.xfer_tag == tid) ? 20'(i + $urandom_range(1, 3)) : 20'(i);
        send(c);
      end
      c = random_cmd();
      c.action = ilc_pkg::ACT_WRITE;
      c.xfer_tag = tid;
      c.offset = 20'(i);
      c.data_byte = img[i];
      send(c);
    end
    // write at the offset after the last byte sent, past the end of the image when all were sent
    if ($urandom_range(0, 7) == 0) begin
      c = random_cmd();
      c.action = ilc_pkg::ACT_WRITE;
      c.xfer_tag = tid;
      c.offset = 20'(n);
      send(c);
    end
    c = random_cmd();
    c.action = ilc_pkg::ACT_COMMIT;
    c.xfer_tag = ($urandom_range(0, 11) == 0) ? tid + 32'd1 : tid;
    c.crc_value = ($urandom_range(0, 9) == 0) ? crc ^ (32'h1 << $urandom_range(0, 31)) : crc;
    send(c);
    repeat ($urandom_range(0, 6)) begin
      c = random_cmd();
      case ($urandom_range(0, 2))
        0: c.action = ilc_pkg::ACT_RUN;
        1: c.action = ilc_pkg::ACT_STOP;
        default: c.action = ilc_pkg::ACT_RESTART;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 4) c.job_req = '0;
      else if (pick < 8) c.job_req = pr_workload;
      send(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      c = random_cmd();
      c.action = ilc_pkg::ACT_DISCARD;
      send(c);
    end
  endtask

  task automatic random_traffic(input int budget);
    int start;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(0, 9) < 7) image_session();
      else repeat ($urandom_range(1, 4)) send(random_cmd());
    end
  endtask

  initial begin : timeout
    #3_000_000;
    $display("image_load_controller_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int phase;
    bit backing;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid <= 1'b0;
    in_action <= '0;
    in_xfer_tag <= '0;
    in_manifest_ok <= 1'b0;
    in_img_len <= '0;
    in_dest_addr <= '0;
    in_crc_value <= '0;
    in_offset <= '0;
    in_data_byte <= '0;
    in_job_req <= '0;
    drv_has_fixed <= 1'b0;
    drv_fixed <= '0;
    mismatches = 0;
    words_sent = 0;
    no_gaps = 0;
    hold_cycles = 0;
    pr_backing = 1'b1;
    clear_model();

    add_checked(mk_cmd(ilc_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 8'hff, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ACT_UNUSED, '1, 1, '1, '1, '1, '1, '1, '1),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    // begin refusals: no manifest, zero size, image past top of memory
    add_checked(mk_cmd(ilc_pkg::ACT_BEGIN, 1, 0, 4, 0, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_BEGIN, 1, 1, 0, 0, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_BEGIN, 1, 1, 2, 20'hfffff, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    // whole address space
    add_checked(mk_cmd(ilc_pkg::ACT_BEGIN, '1, 1, 21'h100000, 0, 0, 0, 0, 0),
                mk_res(1, ilc_pkg::ST_RECEIVING, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, '1, 0, 0, 0, 0, 0, 8'hff, 0),
                mk_res(1, ilc_pkg::ST_RECEIVING, 1, 0, 8'hff, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, '1, 0, 0, 0, 0, 5, 8'h11, 0),
                mk_res(0, ilc_pkg::ST_RECEIVING, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 1, 8'h22, 0),
                mk_res(0, ilc_pkg::ST_RECEIVING, 0, 0, 0, 0, 0));
    // short count faults
    add_checked(mk_cmd(ilc_pkg::ACT_COMMIT, '1, 0, 0, 0, 0, 0, 0, 0),
                mk_res(0, ilc_pkg::ST_FAULTED, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, '1, 0, 0, 0, 0, 1, 0, 0),
                mk_res(0, ilc_pkg::ST_FAULTED, 0, 0, 0, 0, 0));
    // restart from faulted with a one-byte image in the last address
    add_checked(mk_cmd(ilc_pkg::ACT_BEGIN, 0, 1, 1, 20'hfffff, CRC_OF_ZERO_BYTE, 0, 0, 0),
                mk_res(1, ilc_pkg::ST_RECEIVING, 0, 0, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 8'h00, 0),
                mk_res(1, ilc_pkg::ST_RECEIVING, 1, 20'hfffff, 0, 0, 0));
    add_checked(mk_cmd(ilc_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 1, 8'h5a, 0),
                mk_res(0, ilc_pkg::ST_RECEIVING, 0, 0, 0, 0, 0));
    add_predicted(mk_cmd(ilc_pkg::ACT_COMMIT, 0, 0, 0, 0, CRC_OF_ZERO_BYTE, 0, 0, 0));
    add_predicted(mk_cmd(ilc_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0, 0, 0));
    add_predicted(mk_cmd(ilc_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0, 0, 2));
    add_predicted(mk_cmd(ilc_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0, 0, 1));
    add_predicted(mk_cmd(ilc_pkg::ACT_BEGIN, 7, 1, 4, 0, 0, 0, 0, 0));
    add_predicted(mk_cmd(ilc_pkg::ACT_RESTART, 0, 0, 0, 0, 0, 0, 0, 0));
    add_predicted(mk_cmd(ilc_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0, 0, 1));
    add_predicted(mk_cmd(ilc_pkg::ACT_RUN, 0, 0, 0, 0, 0, 0, 0, 1));
    add_checked(mk_cmd(ilc_pkg::ACT_DISCARD, 0, 0, 0, 0, 0, 0, 0, 0),
                mk_res(1, ilc_pkg::ST_EMPTY, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 6; phase++) begin
      backing = !(phase == 1 || phase == 4);
      write_backing(backing);
      if (phase == 0) begin
        foreach (directed_rows[i])
          send_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].res);
      end
      if (phase == 2) begin
        // stall the output long enough that the input backs up
        hold_cycles = 300;
        no_gaps = 1;
        random_traffic(40);
        no_gaps = 0;
      end
      if (phase == 3) begin
        random_traffic(100);
        in_valid <= 1'b0;
        drain_results();
      end
      random_traffic(backing ? 170 : 70);
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("image_load_controller_unit regression: pass");
    end else begin
      $display("image_load_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
